/* sv/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the 1-Wire bus master
// Phase encoding, command modes, register indexes, timer widths and the
// register reset values.
// ----------------------------------------------------------------------------
package owbm_pkg;

	// Width of the slot timers; register values above its range saturate.
	localparam int TIMER_BITS = 10;
	// Width of each timing register.
	localparam int REG_W = 10;
	// Number of timing registers and the width of their index.
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [REG_W-1:0] reg_val_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef timer_t len_arr_t [NUM_REGS];

	localparam timer_t TMAX = {TIMER_BITS{1'b1}};

	// Register indexes.
	localparam reg_idx_t REG_RESET_LOW = 3'd0;
	localparam reg_idx_t REG_PRESENCE_WAIT = 3'd1;
	localparam reg_idx_t REG_RESET_RECOVER = 3'd2;
	localparam reg_idx_t REG_WRITE_START = 3'd3;
	localparam reg_idx_t REG_WRITE_HOLD = 3'd4;
	localparam reg_idx_t REG_READ_LOW = 3'd5;
	localparam reg_idx_t REG_READ_WAIT = 3'd6;
	localparam reg_idx_t REG_READ_RECOVER = 3'd7;

	// Register values after reset, in index order.
	localparam reg_val_t REG_DEFAULTS [NUM_REGS] = '{
		10'd500, 10'd70, 10'd500, 10'd15, 10'd60, 10'd5, 10'd5, 10'd70
	};

	// Command modes.
	localparam logic [2:0] MODE_RESET = 3'd0;
	localparam logic [2:0] MODE_WRITE_BIT = 3'd1;
	localparam logic [2:0] MODE_READ_BIT = 3'd2;
	localparam logic [2:0] MODE_WRITE_BYTE = 3'd3;
	localparam logic [2:0] MODE_READ_BYTE = 3'd4;

	// Bus phases.
	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_RST_LOW = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_REC = 4'd3,
		PH_WR_LOW = 4'd4,
		PH_WR_HOLD = 4'd5,
		PH_WR_REC = 4'd6,
		PH_RD_LOW = 4'd7,
		PH_RD_WAIT = 4'd8,
		PH_RD_REC = 4'd9
	} phase_t;

	// One result beat.
	typedef struct packed {
		logic drive_low;
		logic busy_res;
		logic done_res;
		logic presence_sample;
		logic [7:0] read_data;
	} result_t;

endpackage

/* sv/owbm_if.sv */
// ----------------------------------------------------------------------------
// owbm_if: channel interfaces of the 1-Wire bus master
// The tick channel carries the command and sampled line level; the result
// channel carries line drive and status.
// ----------------------------------------------------------------------------
interface owbm_cmd_if;
	logic valid;
	logic ready;
	logic cmd_valid;
	logic [2:0] mode;
	logic [7:0] cmd_data;
	logic line_in;

	modport source (output valid, cmd_valid, mode, cmd_data, line_in, input ready);
	modport sink (input valid, cmd_valid, mode, cmd_data, line_in, output ready);
endinterface

interface owbm_res_if;
	logic valid;
	logic ready;
	logic drive_low;
	logic busy_res;
	logic done_res;
	logic presence_sample;
	logic [7:0] read_data;

	modport source (output valid, drive_low, busy_res, done_res, presence_sample,
		read_data, input ready);
	modport sink (input valid, drive_low, busy_res, done_res, presence_sample,
		read_data, output ready);
endinterface

/* sv/owbm_regs.sv */
// ----------------------------------------------------------------------------
// owbm_regs: timing register file
// Holds the eight timing registers and presents each as a phase length in
// ticks, saturated to the timer range and never less than one.
// ----------------------------------------------------------------------------
module owbm_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  owbm_pkg::reg_idx_t wr_index,
	input  owbm_pkg::reg_val_t wr_data,
	output owbm_pkg::len_arr_t lens
);
	import owbm_pkg::*;

	localparam int EXT_W = REG_W + TIMER_BITS;

	reg_val_t regs_q [NUM_REGS];
	logic [EXT_W-1:0] ext [NUM_REGS];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= REG_DEFAULTS[i];
		end else if (wr_en) begin
			regs_q[wr_index] <= wr_data;
		end
	end

	// Saturate to the timer range; a zero length counts as one tick.
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			ext[i] = EXT_W'(regs_q[i]);
			if (ext[i] > EXT_W'(TMAX)) lens[i] = TMAX;
			else lens[i] = ext[i][TIMER_BITS-1:0];
			if (lens[i] == '0) lens[i] = timer_t'(1);
		end
	end

endmodule

/* sv/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master
// Runs reset/presence, bit and byte read/write slots, one tick per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the cmd channel is one microsecond tick. It carries an
//   optional command (cmd_valid, mode, cmd_data) and the sampled bus level
//   line_in. Every cmd beat produces exactly one res beat carrying the line
//   drive for that tick, busy, a one-tick done pulse, the last presence
//   sample and the read data (meaningful on the done beat of a read).
//   Commands arriving while busy, and unused modes, are ignored.
//   The result of a tick appears on res in the cycle after its cmd beat. One
//   tick is taken per clock while res does not stall; the bus state update
//   is a single pass through the phase logic into the result register.
//   If res stalls, the one result register stays full and cmd.ready drops
//   until the result is taken; a tick can be accepted in the same cycle a
//   result leaves.
//   The timing registers are written through cfg_wr_en/cfg_index/cfg_data;
//   a new value applies to ticks accepted after the write.
//   Reset (arst_n low) returns to idle with presence sample 1, empties the
//   result register and restores the default timing values.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
	input  logic clk,
	input  logic arst_n,
	owbm_cmd_if.sink cmd,
	owbm_res_if.source res,
	input  logic cfg_wr_en,
	input  owbm_pkg::reg_idx_t cfg_index,
	input  owbm_pkg::reg_val_t cfg_data
);
	import owbm_pkg::*;

	len_arr_t lens;

	phase_t phase_q, phase_d;
	timer_t tick_q, tick_d;
	logic [2:0] bit_idx_q, bit_idx_d;
	logic [7:0] shift_q, shift_d;
	logic byte_op_q, byte_op_d;
	logic read_mode_q, read_mode_d;
	logic presence_q, presence_d;

	logic res_valid_q;
	result_t res_q, res_d;
	logic accept;
	logic start;
	logic slot_end;
	logic over;
	timer_t cur_len;
	logic [TIMER_BITS:0] tick_inc;

	owbm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.lens     (lens)
	);

	// Take a tick whenever the result register is empty or being drained.
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept = cmd.valid && cmd.ready;
	assign start = (phase_q == PH_IDLE) && cmd.cmd_valid && (cmd.mode <= MODE_READ_BYTE);

	// Length of the phase that runs this tick.
	always_comb begin
		unique case (start ? (cmd.mode == MODE_RESET ? PH_RST_LOW :
			(cmd.mode == MODE_READ_BIT || cmd.mode == MODE_READ_BYTE) ? PH_RD_LOW :
			PH_WR_LOW) : phase_q)
			PH_RST_LOW: cur_len = lens[REG_RESET_LOW];
			PH_RST_WAIT: cur_len = lens[REG_PRESENCE_WAIT];
			PH_RST_REC: cur_len = lens[REG_RESET_RECOVER];
			PH_WR_LOW: cur_len = lens[REG_WRITE_START];
			PH_WR_HOLD: cur_len = lens[REG_WRITE_HOLD];
			PH_RD_LOW: cur_len = lens[REG_READ_LOW];
			PH_RD_WAIT: cur_len = lens[REG_READ_WAIT];
			PH_RD_REC: cur_len = lens[REG_READ_RECOVER];
			default: cur_len = lens[REG_RESET_LOW];
		endcase
	end

	// Next state and result for one tick.
	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		bit_idx_d = bit_idx_q;
		shift_d = shift_q;
		byte_op_d = byte_op_q;
		read_mode_d = read_mode_q;
		presence_d = presence_q;
		slot_end = 1'b0;
		res_d = '0;

		// Command start.
		if (start) begin
			tick_d = '0;
			bit_idx_d = '0;
			byte_op_d = (cmd.mode >= MODE_WRITE_BYTE);
			read_mode_d = (cmd.mode == MODE_READ_BIT) || (cmd.mode == MODE_READ_BYTE);
			if (cmd.mode == MODE_WRITE_BIT) shift_d = {7'b0, cmd.cmd_data[0]};
			else if (cmd.mode == MODE_WRITE_BYTE) shift_d = cmd.cmd_data;
			else shift_d = '0;
			if (cmd.mode == MODE_RESET) phase_d = PH_RST_LOW;
			else if (read_mode_d) phase_d = PH_RD_LOW;
			else phase_d = PH_WR_LOW;
		end

		// Phase timer: wraps to zero on the last tick of a phase.
		tick_inc = {1'b0, tick_d} + 1'b1;
		over = (tick_inc >= {1'b0, cur_len});

		if (phase_d != PH_IDLE) begin
			res_d.busy_res = 1'b1;
			if (over) tick_d = '0;
			else tick_d = tick_inc[TIMER_BITS-1:0];
			unique case (phase_d)
				PH_RST_LOW: begin
					res_d.drive_low = 1'b1;
					if (over) phase_d = PH_RST_WAIT;
				end
				PH_RST_WAIT: begin
					if (over) begin
						presence_d = cmd.line_in;
						phase_d = PH_RST_REC;
					end
				end
				PH_RST_REC: begin
					if (over) begin
						phase_d = PH_IDLE;
						res_d.done_res = 1'b1;
					end
				end
				PH_WR_LOW: begin
					res_d.drive_low = 1'b1;
					if (over) phase_d = PH_WR_HOLD;
				end
				PH_WR_HOLD: begin
					res_d.drive_low = !shift_d[0];
					if (over) phase_d = PH_WR_REC;
				end
				PH_WR_REC: begin
					tick_d = '0;
					shift_d = {1'b0, shift_d[7:1]};
					slot_end = 1'b1;
				end
				PH_RD_LOW: begin
					res_d.drive_low = 1'b1;
					if (over) phase_d = PH_RD_WAIT;
				end
				PH_RD_WAIT: begin
					if (over) begin
						if (byte_op_d) shift_d = {cmd.line_in, shift_d[7:1]};
						else shift_d = {7'b0, cmd.line_in};
						phase_d = PH_RD_REC;
					end
				end
				PH_RD_REC: begin
					if (over) slot_end = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
					tick_d = '0;
				end
			endcase

			// End of a bit slot: next bit of a byte, or finish.
			if (slot_end) begin
				if (byte_op_d && bit_idx_d != 3'd7) begin
					bit_idx_d = bit_idx_d + 3'd1;
					phase_d = read_mode_d ? PH_RD_LOW : PH_WR_LOW;
				end else begin
					phase_d = PH_IDLE;
					res_d.done_res = 1'b1;
					if (read_mode_d) res_d.read_data = shift_d;
				end
			end
		end
		res_d.presence_sample = presence_d;
	end

	// Bus state, advanced once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_idx_q <= '0;
			shift_q <= '0;
			byte_op_q <= 1'b0;
			read_mode_q <= 1'b0;
			presence_q <= 1'b1;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q <= tick_d;
			bit_idx_q <= bit_idx_d;
			shift_q <= shift_d;
			byte_op_q <= byte_op_d;
			read_mode_q <= read_mode_d;
			presence_q <= presence_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) res_q <= res_d;
	end

	assign res.valid = res_valid_q;
	assign res.drive_low = res_q.drive_low;
	assign res.busy_res = res_q.busy_res;
	assign res.done_res = res_q.done_res;
	assign res.presence_sample = res_q.presence_sample;
	assign res.read_data = res_q.read_data;

	// An idle master always has its phase timer at zero.
	a_idle_timer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (tick_q == '0))
		else $error("phase timer not cleared in idle");

	// A done beat is always a busy beat, and it leaves the master idle.
	a_done_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.done_res) |-> (res_q.busy_res && phase_q == PH_IDLE))
		else $error("done beat without busy or with command still running");

	// Read data is zero except on a done beat.
	a_rdata_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.done_res) |-> (res_q.read_data == 8'd0))
		else $error("read data outside a done beat");

	// Every accepted tick fills the result register.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted tick produced no result");

endmodule
